// ===== src/assert_macros.svh =====
// assertion macros included by the multiplier top
// expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same check, also active while reset is applied
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mmm_pkg.sv =====
// package of the montgomery modular multiplier: widths, register indexes,
// and the single restoring-division step; no dependencies
package mmm_pkg;

	localparam int WIDTH       = 16;               // operand width
	localparam int REG_W       = 16;               // modulus and constant width
	localparam int RB_W        = 5;                // radix_bits width
	localparam int CFG_IDX_W   = 2;
	localparam int MOD_STEP    = 4;                // quotient bits per mod stage
	localparam int MOD_STAGES  = 13;
	localparam int MOD_W       = MOD_STEP * MOD_STAGES;  // dividend width
	localparam int S_W         = 31;               // redc s width (radix up to 31 bits)
	localparam int V_W         = 2 * REG_W;        // am * bm
	localparam int SN_W        = S_W + REG_W;
	localparam int SUM_W       = SN_W + 1;
	localparam int U_W         = V_W + 1;
	localparam int CR_W        = U_W + REG_W;      // c * radix_inverse
	localparam int VLD_LEN     = 2 + MOD_STAGES + 6 + MOD_STAGES;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODULUS       = 2'd0,
		CFG_RADIX_BITS    = 2'd1,
		CFG_NEG_INVERSE   = 2'd2,
		CFG_RADIX_INVERSE = 2'd3
	} cfg_idx_t;

	// one restoring step: shift in one dividend bit, subtract n if it fits
	function automatic logic [REG_W-1:0] mod_step(
		input logic [REG_W-1:0] rem,
		input logic             dbit,
		input logic [REG_W-1:0] n
	);
		logic [REG_W:0] t;
		t = {rem, dbit};
		if (t >= {1'b0, n}) begin
			t = t - {1'b0, n};
		end
		return t[REG_W-1:0];
	endfunction

endpackage

// ===== src/mmm_opnd_if.sv =====
// operand request channel: valid, ready, two operands
// depends on mmm_pkg
interface mmm_opnd_if;
	logic                       valid;
	logic                       ready;
	logic [mmm_pkg::WIDTH-1:0]  operand_a;
	logic [mmm_pkg::WIDTH-1:0]  operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

// ===== src/mmm_rslt_if.sv =====
// result request channel: valid, ready, product
// depends on mmm_pkg
interface mmm_rslt_if;
	logic                       valid;
	logic                       ready;
	logic [mmm_pkg::REG_W-1:0]  product;

	modport source (output valid, output product, input ready);
	modport sink   (input valid, input product, output ready);
endinterface

// ===== src/mmm_mod.sv =====
// pipelined remainder unit: MOD_W-bit dividend mod a 16-bit modulus,
// MOD_STEP restoring steps per stage; depends on mmm_pkg
module mmm_mod (
	input  logic                        clk,
	input  logic                        en,
	input  logic [mmm_pkg::MOD_W-1:0]   x,
	input  logic [mmm_pkg::REG_W-1:0]   n,
	output logic [mmm_pkg::REG_W-1:0]   r
);
	import mmm_pkg::*;

	for (genvar g = 0; g < MOD_STAGES; g++) begin : g_stage
		logic [REG_W-1:0] rem_in, rem_d, rem_s;
		logic [MOD_W-1:0] val_in, val_d, val_s;

		// first stage starts from the raw dividend
		if (g == 0) begin : g_first
			assign rem_in = '0;
			assign val_in = x;
		end else begin : g_next
			assign rem_in = g_stage[g-1].rem_s;
			assign val_in = g_stage[g-1].val_s;
		end

		always_comb begin
			logic [REG_W-1:0] rr;
			logic [MOD_W-1:0] vv;
			rr = rem_in;
			vv = val_in;
			for (int i = 0; i < MOD_STEP; i++) begin
				rr = mod_step(rr, vv[MOD_W-1], n);
				vv = vv << 1;
			end
			rem_d = rr;
			val_d = vv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s <= rem_d;
				val_s <= val_d;
			end
		end
	end

	assign r = g_stage[MOD_STAGES-1].rem_s;

endmodule

// ===== src/montgomery_modular_multiplier_top.sv =====
// path: operand capture, dividends, remainder units a and b, redc stages, remainder unit c, output register
// throughput: one request per cycle; the whole pipeline stalls only while a result waits
// the 13-stage remainder units (4 bits each) set the depth: u_mod_a and u_mod_b in parallel, then u_mod_c
// reset: arst_n clears all valid bits and loads modulus 1, radix_bits 1, constants 0
// depends on mmm_pkg, mmm_opnd_if, mmm_rslt_if, mmm_mod, assert_macros.svh
`include "assert_macros.svh"

module montgomery_modular_multiplier_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mmm_pkg::REG_W-1:0]       cfg_data,
	mmm_opnd_if.sink                        operands,
	mmm_rslt_if.source                      result
);
	import mmm_pkg::*;

	// configuration registers; the user must keep them static while requests are in flight (not enforced by the block)
	logic [REG_W-1:0] modulus_q;
	logic [RB_W-1:0]  radix_bits_q;
	logic [REG_W-1:0] neg_inverse_q;
	logic [REG_W-1:0] radix_inverse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q       <= REG_W'(1);
			radix_bits_q    <= RB_W'(1);
			neg_inverse_q   <= '0;
			radix_inverse_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODULUS:       modulus_q       <= cfg_data;
				CFG_RADIX_BITS:    radix_bits_q    <= cfg_data[RB_W-1:0];
				CFG_NEG_INVERSE:   neg_inverse_q   <= cfg_data;
				CFG_RADIX_INVERSE: radix_inverse_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// even modulus takes the plain a*b mod n path
	logic plain;
	assign plain = ~modulus_q[0];

	// global advance: move unless a finished result is still waiting
	logic en;
	logic out_vld_q;
	assign en = !out_vld_q || result.ready;
	assign operands.ready = en;

	// valid bits travel alongside the data
	logic [VLD_LEN-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[VLD_LEN-2:0], operands.valid};
			out_vld_q <= vld_s[VLD_LEN-1];
		end
	end

	// stage 1: capture operands
	logic [WIDTH-1:0] a_s1, b_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= operands.operand_a;
			b_s1 <= operands.operand_b;
		end
	end

	// stage 2: dividends for the first reduction (a*b on the plain path, else shifted a; b always shifted)
	logic [MOD_W-1:0] xa_s2, xb_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			xa_s2 <= plain ? MOD_W'(V_W'(a_s1) * V_W'(b_s1)) : (MOD_W'(a_s1) << radix_bits_q);
			xb_s2 <= MOD_W'(b_s1) << radix_bits_q;
		end
	end

	logic [REG_W-1:0] am, bm;
	mmm_mod u_mod_a (.clk(clk), .en(en), .x(xa_s2), .n(modulus_q), .r(am));
	mmm_mod u_mod_b (.clk(clk), .en(en), .x(xb_s2), .n(modulus_q), .r(bm));

	// redc: v = am*bm, s = v*k mod R, u = (v + s*n) / R, one conditional subtract
	logic [V_W-1:0]   v_s3, v_s4, v_s5;
	logic [S_W-1:0]   s_s4;
	logic [SN_W-1:0]  sn_s5;
	logic [U_W-1:0]   u_s6, c_s7;
	logic [MOD_W-1:0] xc_s8;
	logic [REG_W-1:0] am_plain_s3, am_plain_s4, am_plain_s5, am_plain_s6, am_plain_s7;

	logic [S_W-1:0]   rmask;
	logic [S_W-1:0]   vk;
	logic [SUM_W-1:0] sum;
	assign rmask = (S_W'(1) << radix_bits_q) - S_W'(1);
	assign vk    = S_W'(v_s3[S_W-1:0] * neg_inverse_q);
	assign sum   = SUM_W'(v_s5) + SUM_W'(sn_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			v_s3        <= am * bm;
			am_plain_s3 <= am;
			s_s4        <= vk & rmask;
			v_s4        <= v_s3;
			am_plain_s4 <= am_plain_s3;
			sn_s5       <= s_s4 * modulus_q;
			v_s5        <= v_s4;
			am_plain_s5 <= am_plain_s4;
			u_s6        <= U_W'(sum >> radix_bits_q);
			am_plain_s6 <= am_plain_s5;
			c_s7        <= (u_s6 >= U_W'(modulus_q)) ? u_s6 - U_W'(modulus_q) : u_s6;
			am_plain_s7 <= am_plain_s6;
			// plain path result is already reduced, so the last unit passes it through
			xc_s8       <= plain ? MOD_W'(am_plain_s7)
			                     : MOD_W'(CR_W'(c_s7) * CR_W'(radix_inverse_q));
		end
	end

	logic [REG_W-1:0] rc;
	mmm_mod u_mod_c (.clk(clk), .en(en), .x(xc_s8), .n(modulus_q), .r(rc));

	// output register; zero modulus forces zero
	logic [REG_W-1:0] product_q;
	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= (modulus_q == '0) ? '0 : rc;
		end
	end

	assign result.valid   = out_vld_q;
	assign result.product = product_q;

	`ASSERT_CLK(a_accept_enters, (operands.valid && operands.ready) |=> vld_s[0], "accepted request lost at pipeline entry")
	`ASSERT_CLK(a_stall_holds, !en |=> ($stable(vld_s) && out_vld_q), "pipeline moved during stall")
	`ASSERT_CLK(a_out_source, $rose(out_vld_q) |-> $past(vld_s[VLD_LEN-1]), "result appeared without a request")

endmodule
